[hw/rtl/rmj_pkg.sv]
package rmj_pkg;

  // Field widths and fixed-point format
  localparam int DATA_W   = 32;
  localparam int FRAC     = 16;
  localparam int CFG_W    = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ROOT_W   = DATA_W;
  localparam int SQ_N     = PROD_W / 2;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int DIV_W    = PROD_W;
  localparam int QW       = DATA_W + 1;
  localparam int Q1_W     = FRAC + 1;
  localparam int MUL_W    = Q1_W + QW;
  localparam int LATENCY  = 2 + SQ_N + QW + 1 + QW + 1;

  localparam logic [CFG_W-1:0] MIN_RANGE_RESET = CFG_W'(1);

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drho_dpx;
    logic signed [DATA_W-1:0] drho_dpy;
    logic signed [DATA_W-1:0] dphi_dpx;
    logic signed [DATA_W-1:0] dphi_dpy;
    logic signed [DATA_W-1:0] drate_dpx;
    logic signed [DATA_W-1:0] drate_dpy;
    logic                     near_origin_error;
  } out_word_t;

  // Control that rides alongside the data through every stage
  typedef struct packed {
    logic valid;
    logic err;
    logic x_neg;
    logic y_neg;
    logic y_pos;
    logic c_neg;
    logic c_pos;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [PROD_W-1:0] s;
    logic [PROD_W-1:0] cm;
    logic [DATA_W-1:0] xm;
    logic [DATA_W-1:0] ym;
  } front_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [ROOT_W-1:0] r;
    logic [PROD_W-1:0] s;
    logic [DATA_W-1:0] xm;
    logic [DATA_W-1:0] ym;
  } side2_t;

  typedef struct packed {
    ctl_t            ctl;
    logic [Q1_W-1:0] q1x;
    logic [Q1_W-1:0] q1y;
  } side3_t;

  typedef struct packed {
    logic          ovf;
    logic [QW-1:0] quot;
  } div_res_t;

  // Apply sign and clamp a quotient magnitude to the signed output range
  function automatic logic [DATA_W-1:0] sat_out(input logic neg, input div_res_t v);
    logic [QW-1:0] lim;
    if (neg) begin
      lim = QW'(1) << (DATA_W - 1);
      if (v.ovf || (v.quot > lim)) return DATA_W'(lim);
      return DATA_W'(QW'(0) - v.quot);
    end
    lim = (QW'(1) << (DATA_W - 1)) - QW'(1);
    if (v.ovf || (v.quot > lim)) return DATA_W'(lim);
    return DATA_W'(v.quot);
  endfunction

endpackage

[hw/rtl/rmj_div.sv]
module rmj_div (
  input  logic                      clk,
  input  logic [rmj_pkg::DIV_W-1:0] dividend,
  input  logic [rmj_pkg::DIV_W-1:0] divisor,
  output rmj_pkg::div_res_t         res
);
  import rmj_pkg::*;

  // One quotient bit per stage, restoring long division
  logic [DIV_W-1:0] rem_r [QW];
  logic [QW-1:0]    lo_r  [QW];
  logic [DIV_W-1:0] dvs_r [QW];
  logic [QW-1:0]    q_r   [QW];
  logic             ovf_r [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      localparam int BIT = QW - 1 - k;
      logic [DIV_W-1:0] rem_in;
      logic [DIV_W-1:0] dvs_in;
      logic [QW-1:0]    lo_in;
      logic [QW-1:0]    q_in;
      logic             ovf_in;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;
      logic             ge;
      logic [DIV_W-1:0] rem_nxt;

      if (k == 0) begin : g_first
        // Quotient beyond QW bits is flagged as overflow up front
        assign rem_in = DIV_W'(dividend[DIV_W-1:QW]);
        assign lo_in  = dividend[QW-1:0];
        assign dvs_in = divisor;
        assign q_in   = '0;
        assign ovf_in = (rem_in >= divisor);
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign lo_in  = lo_r[k-1];
        assign dvs_in = dvs_r[k-1];
        assign q_in   = q_r[k-1];
        assign ovf_in = ovf_r[k-1];
      end

      assign trial   = {rem_in, lo_in[BIT]};
      assign diff    = trial - {1'b0, dvs_in};
      assign ge      = (trial >= {1'b0, dvs_in});
      assign rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        lo_r[k]  <= lo_in;
        dvs_r[k] <= dvs_in;
        ovf_r[k] <= ovf_in;
        q_r[k]   <= q_in | (QW'(ge) << BIT);
      end
    end
  endgenerate

  assign res.ovf  = ovf_r[QW-1];
  assign res.quot = q_r[QW-1];

endmodule

[hw/rtl/rmj_sqrt.sv]
module rmj_sqrt (
  input  logic                       clk,
  input  logic [rmj_pkg::PROD_W-1:0] rad,
  output logic [rmj_pkg::ROOT_W-1:0] root
);
  import rmj_pkg::*;

  // Digit-by-digit square root, two radicand bits per stage
  logic [SQ_REM_W-1:0] rem_r  [SQ_N];
  logic [ROOT_W-1:0]   root_r [SQ_N];
  logic [PROD_W-1:0]   rad_r  [SQ_N];

  genvar k;
  generate
    for (k = 0; k < SQ_N; k++) begin : g_stage
      localparam int P = 2 * (SQ_N - 1 - k);
      logic [SQ_REM_W-1:0] rem_in;
      logic [ROOT_W-1:0]   root_in;
      logic [PROD_W-1:0]   rad_in;
      logic [SQ_REM_W-1:0] acc;
      logic [SQ_REM_W-1:0] trial;
      logic                ge;
      logic [SQ_REM_W-1:0] rem_nxt;

      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = rad;
      end else begin : g_next
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign rad_in  = rad_r[k-1];
      end

      assign acc     = {rem_in[SQ_REM_W-3:0], rad_in[P+1:P]};
      assign trial   = {root_in, 2'b01};
      assign ge      = (acc >= trial);
      assign rem_nxt = ge ? (acc - trial) : acc;

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        rad_r[k]  <= rad_in;
      end
    end
  endgenerate

  assign root = root_r[SQ_N-1];

endmodule

[hw/rtl/rmj_front.sv]
module rmj_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  rmj_pkg::in_word_t         in_word,
  input  logic [rmj_pkg::CFG_W-1:0] min_range,
  output rmj_pkg::front_t           q
);
  import rmj_pkg::*;

  logic                     v1_r;
  logic                     x_neg1_r;
  logic                     y_neg1_r;
  logic                     y_pos1_r;
  logic [DATA_W-1:0]        xm1_r;
  logic [DATA_W-1:0]        ym1_r;
  logic [PROD_W-1:0]        sqx_r;
  logic [PROD_W-1:0]        sqy_r;
  logic signed [PROD_W-1:0] pa_r;
  logic signed [PROD_W-1:0] pb_r;
  logic [DATA_W-1:0]        xm_nxt;
  logic [DATA_W-1:0]        ym_nxt;
  logic signed [PROD_W-1:0] pa_nxt;
  logic signed [PROD_W-1:0] pb_nxt;
  logic [PROD_W-1:0]        s_nxt;
  logic signed [PROD_W:0]   c_nxt;
  logic [PROD_W:0]          cm_nxt;
  logic [PROD_W-1:0]        thr;
  front_t                   q_r;

  // Stage one: magnitudes, squares and cross products
  assign xm_nxt = in_word.pos_x[DATA_W-1] ? (~in_word.pos_x + 1'b1) : in_word.pos_x;
  assign ym_nxt = in_word.pos_y[DATA_W-1] ? (~in_word.pos_y + 1'b1) : in_word.pos_y;
  assign pa_nxt = in_word.vel_x * in_word.pos_y;
  assign pb_nxt = in_word.vel_y * in_word.pos_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_neg1_r <= in_word.pos_x[DATA_W-1];
    y_neg1_r <= in_word.pos_y[DATA_W-1];
    y_pos1_r <= !in_word.pos_y[DATA_W-1] && (in_word.pos_y != '0);
    xm1_r    <= xm_nxt;
    ym1_r    <= ym_nxt;
    sqx_r    <= PROD_W'(xm_nxt) * PROD_W'(xm_nxt);
    sqy_r    <= PROD_W'(ym_nxt) * PROD_W'(ym_nxt);
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
  end

  // Stage two: radius squared, cross term, range check
  assign s_nxt  = sqx_r + sqy_r;
  assign c_nxt  = {pa_r[PROD_W-1], pa_r} - {pb_r[PROD_W-1], pb_r};
  assign cm_nxt = c_nxt[PROD_W] ? (~c_nxt + 1'b1) : c_nxt;
  assign thr    = PROD_W'({min_range, {FRAC{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctl.valid <= 1'b0;
    end else begin
      q_r.ctl.valid <= v1_r;
    end
    q_r.ctl.err   <= (s_nxt == '0) || (s_nxt < thr);
    q_r.ctl.x_neg <= x_neg1_r;
    q_r.ctl.y_neg <= y_neg1_r;
    q_r.ctl.y_pos <= y_pos1_r;
    q_r.ctl.c_neg <= c_nxt[PROD_W];
    q_r.ctl.c_pos <= !c_nxt[PROD_W] && (c_nxt != '0);
    q_r.s         <= s_nxt;
    q_r.cm        <= cm_nxt[PROD_W-1:0];
    q_r.xm        <= xm1_r;
    q_r.ym        <= ym1_r;
  end

  assign q = q_r;

endmodule

[hw/rtl/radar_measurement_jacobian_top.sv]
// Radar measurement Jacobian: takes a state word (px, py, vx, vy, Q15.16) and returns
// the six distinct Jacobian entries, one word per cycle sustained. busy never rises,
// so a word may be started every cycle; the receiver cannot stall and each result
// is shown for one cycle with out_valid high. The pipeline is a 32-stage square root
// and two chained 33-stage dividers, plus two front stages, one multiply stage and
// the output register. When px^2 + py^2 is zero or below min_range_squared (Q16.16),
// near_origin_error is set and all entries read zero. min_range_squared resets to 1
// LSB; the user must write it through the cfg port while idle, unenforced by the block.
module radar_measurement_jacobian_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rmj_pkg::in_word_t         in_data,
  output logic                      out_valid,
  output rmj_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rmj_pkg::CFG_W-1:0] cfg_data
);
  import rmj_pkg::*;

  logic [CFG_W-1:0] min_range_r;
  front_t           front_q;
  logic [ROOT_W-1:0] root;
  front_t           side1_r [SQ_N];
  front_t           f1;
  side2_t           side2_nxt;
  side2_t           side2_r [QW];
  side2_t           f2;
  div_res_t         q1x_res;
  div_res_t         q1y_res;
  div_res_t         q2_res;
  side2_t           mside_r;
  logic [Q1_W-1:0]  q1x_r;
  logic [Q1_W-1:0]  q1y_r;
  logic [MUL_W-1:0] prod_x_r;
  logic [MUL_W-1:0] prod_y_r;
  side3_t           side3_r [QW];
  side3_t           f3;
  div_res_t         drate_x_res;
  div_res_t         drate_y_res;
  div_res_t         dphi_x_res;
  div_res_t         dphi_y_res;
  div_res_t         q1x_out;
  div_res_t         q1y_out;
  out_word_t        out_nxt;
  logic             out_valid_r;
  out_word_t        out_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold the range threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= MIN_RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_range_r <= cfg_data;
    end
  end

  rmj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_word   (in_data),
    .min_range (min_range_r),
    .q         (front_q)
  );

  rmj_sqrt u_sqrt (
    .clk  (clk),
    .rad  (front_q.s),
    .root (root)
  );

  // Carry the word alongside the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_N; i++) begin
        side1_r[i].ctl.valid <= 1'b0;
      end
    end else begin
      side1_r[0] <= front_q;
      for (int i = 1; i < SQ_N; i++) begin
        side1_r[i] <= side1_r[i-1];
      end
    end
  end

  assign f1 = side1_r[SQ_N-1];

  // First divider bank: p / rho and cross term / rho
  rmj_div u_div_q1x (
    .clk      (clk),
    .dividend (DIV_W'({f1.xm, {FRAC{1'b0}}})),
    .divisor  (DIV_W'(root)),
    .res      (q1x_res)
  );

  rmj_div u_div_q1y (
    .clk      (clk),
    .dividend (DIV_W'({f1.ym, {FRAC{1'b0}}})),
    .divisor  (DIV_W'(root)),
    .res      (q1y_res)
  );

  rmj_div u_div_q2 (
    .clk      (clk),
    .dividend (f1.cm),
    .divisor  (DIV_W'(root)),
    .res      (q2_res)
  );

  assign side2_nxt.ctl = f1.ctl;
  assign side2_nxt.r   = root;
  assign side2_nxt.s   = f1.s;
  assign side2_nxt.xm  = f1.xm;
  assign side2_nxt.ym  = f1.ym;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        side2_r[i].ctl.valid <= 1'b0;
      end
    end else begin
      side2_r[0] <= side2_nxt;
      for (int i = 1; i < QW; i++) begin
        side2_r[i] <= side2_r[i-1];
      end
    end
  end

  assign f2 = side2_r[QW-1];

  // Multiply stage: (p / rho) * (cross / rho)
  always_ff @(posedge clk) begin
    q1x_r    <= q1x_res.quot[Q1_W-1:0];
    q1y_r    <= q1y_res.quot[Q1_W-1:0];
    prod_x_r <= MUL_W'(q1x_res.quot[Q1_W-1:0]) * MUL_W'(q2_res.quot);
    prod_y_r <= MUL_W'(q1y_res.quot[Q1_W-1:0]) * MUL_W'(q2_res.quot);
    if (!rst_n) begin
      mside_r.ctl.valid <= 1'b0;
    end else begin
      mside_r <= f2;
    end
  end

  // Second divider bank: range-rate and bearing entries
  rmj_div u_div_drate_x (
    .clk      (clk),
    .dividend (DIV_W'(prod_y_r)),
    .divisor  (DIV_W'(mside_r.r)),
    .res      (drate_x_res)
  );

  rmj_div u_div_drate_y (
    .clk      (clk),
    .dividend (DIV_W'(prod_x_r)),
    .divisor  (DIV_W'(mside_r.r)),
    .res      (drate_y_res)
  );

  rmj_div u_div_dphi_x (
    .clk      (clk),
    .dividend (DIV_W'({mside_r.ym, {(2 * FRAC){1'b0}}})),
    .divisor  (mside_r.s),
    .res      (dphi_x_res)
  );

  rmj_div u_div_dphi_y (
    .clk      (clk),
    .dividend (DIV_W'({mside_r.xm, {(2 * FRAC){1'b0}}})),
    .divisor  (mside_r.s),
    .res      (dphi_y_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        side3_r[i].ctl.valid <= 1'b0;
      end
    end else begin
      side3_r[0].ctl <= mside_r.ctl;
      side3_r[0].q1x <= q1x_r;
      side3_r[0].q1y <= q1y_r;
      for (int i = 1; i < QW; i++) begin
        side3_r[i] <= side3_r[i-1];
      end
    end
  end

  assign f3 = side3_r[QW-1];

  // Sign, clamp and blank on the near-origin case
  assign q1x_out = '{ovf: 1'b0, quot: QW'(f3.q1x)};
  assign q1y_out = '{ovf: 1'b0, quot: QW'(f3.q1y)};

  always_comb begin
    out_nxt = '0;
    if (f3.ctl.err) begin
      out_nxt.near_origin_error = 1'b1;
    end else begin
      out_nxt.drho_dpx  = sat_out(f3.ctl.x_neg, q1x_out);
      out_nxt.drho_dpy  = sat_out(f3.ctl.y_neg, q1y_out);
      out_nxt.dphi_dpx  = sat_out(f3.ctl.y_pos, dphi_x_res);
      out_nxt.dphi_dpy  = sat_out(f3.ctl.x_neg, dphi_y_res);
      out_nxt.drate_dpx = sat_out(f3.ctl.y_neg != f3.ctl.c_neg, drate_x_res);
      out_nxt.drate_dpy = sat_out(f3.ctl.x_neg != f3.ctl.c_pos, drate_y_res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f3.ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result only ever follows a start issued one latency earlier
  a_result_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching start");

  // Rejected words carry all-zero entries
  a_error_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.near_origin_error) |->
      (out_data.drho_dpx == '0 && out_data.drho_dpy == '0 &&
       out_data.dphi_dpx == '0 && out_data.dphi_dpy == '0 &&
       out_data.drate_dpx == '0 && out_data.drate_dpy == '0))
    else $error("near-origin result not blanked");

  // Range derivatives are direction cosines, never beyond one
  a_unit_cosine: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.drho_dpx <= $signed(DATA_W'(1) << FRAC) &&
       out_data.drho_dpx >= -$signed(DATA_W'(1) << FRAC) &&
       out_data.drho_dpy <= $signed(DATA_W'(1) << FRAC) &&
       out_data.drho_dpy >= -$signed(DATA_W'(1) << FRAC)))
    else $error("range derivative magnitude above one");

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmj_pkg::*;

  localparam int RANDOM_PER_PHASE = 285;

  // Expected Jacobian words and the range threshold that the block holds
  class jacobian_scoreboard;
    out_word_t            pending[$];
    logic [CFG_W-1:0]     min_range_sq;
    int                   mismatches;

    function new();
      min_range_sq = MIN_RANGE_RESET;
      mismatches = 0;
    endfunction

    // Integer square root, floor, bit by bit
    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // Apply the sign and clamp to the signed output range
    function logic signed [DATA_W-1:0] clamp_signed(logic neg, logic [63:0] mag);
      logic [63:0] lim;
      if (neg) begin
        lim = 64'd1 << (DATA_W - 1);
        if (mag > lim) mag = lim;
        return DATA_W'(64'd0 - mag);
      end
      lim = (64'd1 << (DATA_W - 1)) - 64'd1;
      if (mag > lim) mag = lim;
      return DATA_W'(mag);
    endfunction

    function out_word_t jacobian_of(in_word_t w);
      out_word_t o;
      logic signed [64:0] x, y, vx, vy, c;
      logic [63:0] xm, ym, s, r, cm, q1x, q1y, q2, thr;
      x = w.pos_x;
      y = w.pos_y;
      vx = w.vel_x;
      vy = w.vel_y;
      xm = x < 0 ? 64'(-x) : 64'(x);
      ym = y < 0 ? 64'(-y) : 64'(y);
      s = xm * xm + ym * ym;
      thr = 64'(min_range_sq) << FRAC;
      o = '0;
      if (s == 0 || s < thr) begin
        o.near_origin_error = 1'b1;
        return o;
      end
      r = floor_sqrt(s);
      c = vx * y - vy * x;
      cm = c < 0 ? 64'(-c) : 64'(c);
      q1x = (xm << FRAC) / r;
      q1y = (ym << FRAC) / r;
      q2 = cm / r;
      o.drho_dpx = clamp_signed(x < 0, q1x);
      o.drho_dpy = clamp_signed(y < 0, q1y);
      o.dphi_dpx = clamp_signed(y > 0, (ym << (2 * FRAC)) / s);
      o.dphi_dpy = clamp_signed(x < 0, (xm << (2 * FRAC)) / s);
      o.drate_dpx = clamp_signed((y < 0) != (c < 0), (q1y * q2) / r);
      o.drate_dpy = clamp_signed((x < 0) != (c > 0), (q1x * q2) / r);
      o.near_origin_error = 1'b0;
      return o;
    endfunction

    function void note_input(in_word_t w);
      pending.push_back(jacobian_of(w));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", got.drho_dpx, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.drho_dpx !== want.drho_dpx)
        report_mismatch("drho_dpx", got.drho_dpx, want.drho_dpx);
      if (got.drho_dpy !== want.drho_dpy)
        report_mismatch("drho_dpy", got.drho_dpy, want.drho_dpy);
      if (got.dphi_dpx !== want.dphi_dpx)
        report_mismatch("dphi_dpx", got.dphi_dpx, want.dphi_dpx);
      if (got.dphi_dpy !== want.dphi_dpy)
        report_mismatch("dphi_dpy", got.dphi_dpy, want.dphi_dpy);
      if (got.drate_dpx !== want.drate_dpx)
        report_mismatch("drate_dpx", got.drate_dpx, want.drate_dpx);
      if (got.drate_dpy !== want.drate_dpy)
        report_mismatch("drate_dpy", got.drate_dpy, want.drate_dpy);
      if (got.near_origin_error !== want.near_origin_error)
        report_mismatch("near_origin_error", 32'(got.near_origin_error),
                        32'(want.near_origin_error));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_word_t           in_data = '0;
  logic               out_valid;
  out_word_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;
  int                 idle_pct = 0;
  jacobian_scoreboard sb = new();

  radar_measurement_jacobian_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted words, threshold writes and results at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (cfg_valid && cfg_ready) sb.min_range_sq = cfg_data;
      if (out_valid) sb.check_result(out_data);
    end
  end

  // Send one word, idling first at the phase's rate
  task send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task send_state(int px, int py, int vx, int vy);
    in_word_t w;
    w.pos_x = px;
    w.pos_y = py;
    w.vel_x = vx;
    w.vel_y = vy;
    send_word(w);
  endtask

  // Drain the pipeline, then write the threshold while idle
  task write_threshold(logic [CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random field: full range or shrunk to a random magnitude
  function logic signed [31:0] rand_field();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(2) == 0) return v;
    return v >>> $urandom_range(30, 4);
  endfunction

  task random_phase(int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.pos_x = rand_field();
      w.pos_y = rand_field();
      w.vel_x = rand_field();
      w.vel_y = rand_field();
      if ($urandom_range(19) == 0) begin
        w.pos_x = $urandom_range(3) - 1;
        w.pos_y = $urandom_range(3) - 1;
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: origin, extremes, near threshold, saturation
    send_state(0, 0, 0, 0);
    send_state(0, 0, 32'sh7fffffff, 32'sh80000000);
    send_state(1, 0, 0, 0);
    send_state(0, -1, 5, 5);
    send_state(255, 0, 1, 1);
    send_state(256, 0, 1, 1);
    send_state(0, 256, -1, 7);
    send_state(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_state(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_state(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_state(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_state(32'sh80000000, 0, 0, 32'sh7fffffff);
    send_state(0, 32'sh80000000, 32'sh7fffffff, 0);
    send_state(65536, 65536, 65536, -65536);
    send_state(-65536, 131072, -3 * 65536, 65536);
    send_state(1, 1, 32'sh7fffffff, 32'sh80000000);
    send_state(-1, 1, 32'sh80000000, 32'sh80000000);
    send_state(300, -300, 32'sh7fffffff, 32'sh7fffffff);
    send_state(32'shffffffff, 32'shffffffff, -1, -1);

    idle_pct = 0;
    random_phase(RANDOM_PER_PHASE);
    write_threshold('0);
    send_state(0, 0, 1, 1);
    send_state(1, 0, 1, 1);
    idle_pct = 74;
    random_phase(RANDOM_PER_PHASE);
    write_threshold('1);
    send_state(32'sh00ffffff, 0, 1, 1);
    send_state(32'sh01000000, 0, 1, 1);
    idle_pct = 24;
    random_phase(RANDOM_PER_PHASE);
    write_threshold(32'd100);
    idle_pct = 0;
    random_phase(RANDOM_PER_PHASE / 2);
    idle_pct = 74;
    random_phase(RANDOM_PER_PHASE / 2);

    // Drain and settle
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
